// File: rtl/core/hmap_pkg.sv
// ---------------------------------------------------------------------------
// hmap_pkg
// Shared types and constants for the hash map block: request and status
// codes, the stored entry layout and the controller/datapath interface.
// ---------------------------------------------------------------------------
package hmap_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned REQ_W = 2;
  localparam int unsigned ST_W  = 2;

  // request codes, code 3 is a no-op
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  // response status codes
  typedef enum logic [ST_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // one way of a bucket row
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    logic             valid;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic rem_step;
    logic rd;
    logic eval;
    logic out_load;
  } hmap_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic rem_last;
    logic out_busy;
  } hmap_stat_t;

endpackage

// File: rtl/core/hmap_ram.sv
// ---------------------------------------------------------------------------
// hmap_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read data output.
// ---------------------------------------------------------------------------
module hmap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hmap_dp.sv
// ---------------------------------------------------------------------------
// hmap_dp
// Datapath: request registers, reciprocal bucket remainder, bucket row
// memory with way compare and update, clearing counter and output register.
// ---------------------------------------------------------------------------
module hmap_dp
  import hmap_pkg::*;
#(
  parameter int unsigned BUCKETS = 128,
  parameter int unsigned WAYS    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hmap_cmd_t        cmd_i,
  output hmap_stat_t       stat_o,
  input  req_e             req_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [ST_W-1:0]  status_o,
  output logic [VAL_W-1:0] found_o
);

  localparam int unsigned IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W  = WAYS * ENT_W;
  localparam bit          Pow2   = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int unsigned RCP_W  = 32;
  localparam int unsigned PROD_W = KEY_W + RCP_W;
  // ceil(2^(KEY_W+IDX_W) / BUCKETS), exact quotient for every key
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << (KEY_W + IDX_W)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [IDX_W-1:0] B_LO = IDX_W'(BUCKETS);

  // request registers
  req_e             req_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  // remainder unit
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  quo_lo;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic              rem_cnt_q;

  // clearing counter
  logic [IDX_W-1:0] clr_cnt_q;

  // memory interface
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [IDX_W-1:0] bucket;

  // row evaluation
  entry_t [WAYS-1:0] row_rd;
  entry_t [WAYS-1:0] row_wr;
  logic              hit_any, free_any, wr_need;
  logic [WAY_W-1:0]  hit_idx, free_idx;
  status_e           res_status_d, res_status_q;
  logic [VAL_W-1:0]  res_found_d, res_found_q;

  // output register
  logic             out_valid_q;
  logic [ST_W-1:0]  out_status_q;
  logic [VAL_W-1:0] out_found_q;

  // remainder from the low bits of key minus quotient times BUCKETS
  assign quo_lo = prod_q[KEY_W+IDX_W +: IDX_W];
  assign rem_d  = key_q[IDX_W-1:0] - quo_lo * B_LO;

  assign bucket = Pow2 ? key_q[IDX_W-1:0] : rem_q;

  // payload capture, reciprocal multiply then remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      key_q   <= key_i;
      value_q <= value_i;
    end else if (cmd_i.rem_step) begin
      if (rem_cnt_q) begin
        rem_q <= rem_d;
      end else begin
        prod_q <= PROD_W'(key_q) * PROD_W'(RECIP);
      end
    end
  end

  // step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_cnt_q <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rem_cnt_q <= 1'b0;
      end else if (cmd_i.rem_step) begin
        rem_cnt_q <= 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // bucket row store
  hmap_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (bucket),
    .rdata_o (ram_rdata)
  );

  assign row_rd = ram_rdata;

  // compare all ways, pick the lowest hit and lowest free way
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && row_rd[w].valid && row_rd[w].key == key_q) begin
        hit_any = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!free_any && !row_rd[w].valid) begin
        free_any = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
  end

  // row update and response
  always_comb begin
    row_wr       = row_rd;
    wr_need      = 1'b0;
    res_status_d = ST_DONE;
    res_found_d  = '0;
    unique case (req_q)
      REQ_INSERT: begin
        if (hit_any) begin
          row_wr[hit_idx].value = value_q;
          wr_need               = 1'b1;
        end else if (free_any) begin
          row_wr[free_idx].value = value_q;
          row_wr[free_idx].key   = key_q;
          row_wr[free_idx].valid = 1'b1;
          wr_need                = 1'b1;
        end else begin
          res_status_d = ST_FULL;
        end
      end
      REQ_SEARCH: begin
        if (hit_any) begin
          res_found_d = row_rd[hit_idx].value;
        end else begin
          res_status_d = ST_MISS;
        end
      end
      REQ_REMOVE: begin
        if (hit_any) begin
          row_wr[hit_idx] = '0;
          wr_need         = 1'b1;
        end else begin
          res_status_d = ST_MISS;
        end
      end
      default: begin
        res_status_d = ST_DONE;
      end
    endcase
  end

  // write port: clearing pass or write-back
  assign ram_we    = cmd_i.clr_step | (cmd_i.eval & wr_need);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : bucket;
  assign ram_wdata = cmd_i.clr_step ? '0 : row_wr;

  // response hold
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;

  // status to controller
  assign stat_o.clr_last = clr_cnt_q == IDX_W'(BUCKETS - 1);
  assign stat_o.rem_last = rem_cnt_q;
  assign stat_o.out_busy = out_valid_q;

endmodule

// File: rtl/core/hmap_ctrl.sv
// ---------------------------------------------------------------------------
// hmap_ctrl
// Controller: clearing pass after reset, then per request the remainder steps
// (non power-of-two BUCKETS), row read, evaluate/write-back, response hand-off.
// ---------------------------------------------------------------------------
module hmap_ctrl
  import hmap_pkg::*;
#(
  parameter int unsigned BUCKETS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  input  hmap_stat_t stat_i,
  output hmap_cmd_t  cmd_o
);

  localparam bit Pow2 = (BUCKETS & (BUCKETS - 1)) == 0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i & in_ready_q;
  assign out_free = !stat_i.out_busy | out_ready_i;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_step = state_q == S_CLEAR;
    cmd_o.load     = accept;
    cmd_o.rem_step = state_q == S_HASH;
    cmd_o.rd       = state_q == S_READ;
    cmd_o.eval     = state_q == S_EVAL;
    cmd_o.out_load = (state_q == S_RESP) & out_free;
  end

  // state and ready register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (stat_i.clr_last) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            in_ready_q <= 1'b0;
            state_q    <= Pow2 ? S_READ : S_HASH;
          end
        end
        S_HASH: begin
          if (stat_i.rem_last) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_CLEAR;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// File: rtl/core/hash_map_insert_search_remove.sv
// ---------------------------------------------------------------------------
// hash_map_insert_search_remove
// Key-value table of BUCKETS rows with WAYS entries each; insert, search
// and remove requests answered with a status and a found value.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser
//  s_axis   | in  | [30:0] key, [62:31] value      | [1:0] req_type
//  m_axis   | out | [31:0] found_value             | [1:0] status
//
//  After reset a clearing pass writes every bucket row with s_axis_tready
//  low. From accept to the next accept a request goes through row read,
//  compare with write-back, result hand-off and ready. A non power-of-two
//  BUCKETS adds a reciprocal multiply and a remainder step before the read.
//  A result waits in the output register; a stalled m_axis holds back
//  only the next result hand-off.
// ---------------------------------------------------------------------------
module hash_map_insert_search_remove
  import hmap_pkg::*;
#(
  parameter int unsigned BUCKETS = 128,
  parameter int unsigned WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [30:0] key, [62:31] value, [63] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] found_value
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  hmap_cmd_t  cmd;
  hmap_stat_t stat;

  // controller
  hmap_ctrl #(
    .BUCKETS (BUCKETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  hmap_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req_e'(s_axis_tuser)),
    .key_i       (s_axis_tdata[KEY_W-1:0]),
    .value_i     (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_o    (m_axis_tuser),
    .found_o     (m_axis_tdata)
  );

  // one request in flight: ready drops right after an accept
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // a waiting result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!stat.out_busy || m_axis_tready))
    else $error("output register overwritten");

  // no request taken during the clearing pass
  a_clear_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !s_axis_tready)
    else $error("ready during clearing pass");

  // evaluation always uses a row read in the previous cycle
  a_eval_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |-> $past(cmd.rd))
    else $error("row evaluated without a preceding read");

endmodule
